[sv/ipv4_dotted_quad_parse_unit_assert.svh]
// Assertion macros for the dotted-quad parser checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef IPV4_DOTTED_QUAD_PARSE_UNIT_ASSERT_SVH
`define IPV4_DOTTED_QUAD_PARSE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IPV4DQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ipv4dq assertion failed");

// Next-cycle implication, checked out of reset.
`define IPV4DQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ipv4dq assertion failed");

`endif

[sv/ipv4dq_pkg.sv]
// Shared constants and types for the dotted-quad address parser.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package ipv4dq_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned OctetW  = 10;
  localparam int unsigned CountW  = 2;
  localparam int unsigned DoneW   = 24;

  localparam logic [CharW-1:0]  DotChar   = 8'h2E;
  localparam logic [CharW-1:0]  ZeroChar  = 8'h30;
  localparam logic [CharW-1:0]  NineChar  = 8'h39;
  localparam logic [OctetW-1:0] OctetMax  = 10'd255;
  localparam logic [CountW-1:0] MaxDigits = 2'd3;
  localparam logic [CountW-1:0] LastIndex = 2'd3;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic             valid_res;
  } result_t;

endpackage

`default_nettype wire

[sv/ipv4dq_char_if.sv]
// Character channel: one address character per word, with an end flag.
// Depends on ipv4dq_pkg for the character width.
`default_nettype none

interface ipv4dq_char_if;
  logic                          valid;
  logic                          ready;
  logic [ipv4dq_pkg::CharW-1:0]  char_code;
  logic                          last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

[sv/ipv4dq_addr_if.sv]
// Result channel: one parsed address and its valid flag per word.
// Depends on ipv4dq_pkg for the address width.
`default_nettype none

interface ipv4dq_addr_if;
  logic                          valid;
  logic                          ready;
  logic [ipv4dq_pkg::AddrW-1:0]  address;
  logic                          valid_res;

  modport source (output valid, output address, output valid_res, input ready);
  modport sink   (input valid, input address, input valid_res, output ready);
endinterface

`default_nettype wire

[sv/ipv4dq_core.sv]
// Parse state of the current address string and its per-character update.
// Depends on ipv4dq_pkg; produces the result for a final character.
`default_nettype none

module ipv4dq_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [ipv4dq_pkg::CharW-1:0] char_code_i,
  input  wire logic                         last_char_i,
  output ipv4dq_pkg::result_t               result_o
);

  logic [ipv4dq_pkg::OctetW-1:0] octet_value_q, octet_value_d;
  logic [ipv4dq_pkg::CountW-1:0] digit_count_q, digit_count_d;
  logic [ipv4dq_pkg::CountW-1:0] octet_index_q, octet_index_d;
  logic [ipv4dq_pkg::DoneW-1:0]  done_octets_q, done_octets_d;
  logic                          parse_error_q, parse_error_d;

  logic                          is_digit;
  logic                          is_dot;
  logic [ipv4dq_pkg::OctetW-1:0] octet_mac;
  logic                          ok;

  assign is_digit = (char_code_i >= ipv4dq_pkg::ZeroChar) &&
                    (char_code_i <= ipv4dq_pkg::NineChar);
  assign is_dot   = (char_code_i == ipv4dq_pkg::DotChar);

  // value * 10 + digit, as (value << 3) + (value << 1) + digit, modulo 1024.
  assign octet_mac = {octet_value_q[6:0], 3'b000} + {octet_value_q[8:0], 1'b0} +
                     {6'd0, char_code_i[3:0]};

  always_comb begin
    octet_value_d = octet_value_q;
    digit_count_d = digit_count_q;
    octet_index_d = octet_index_q;
    done_octets_d = done_octets_q;
    parse_error_d = parse_error_q;
    if (!parse_error_q) begin
      if (is_digit) begin
        if (digit_count_q == ipv4dq_pkg::MaxDigits) begin
          parse_error_d = 1'b1;
        end else begin
          octet_value_d = octet_mac;
          digit_count_d = digit_count_q + 2'd1;
        end
      end else if (is_dot) begin
        if ((digit_count_q == '0) || (octet_index_q == ipv4dq_pkg::LastIndex) ||
            (octet_value_q > ipv4dq_pkg::OctetMax)) begin
          parse_error_d = 1'b1;
        end else begin
          done_octets_d = {done_octets_q[15:0], octet_value_q[7:0]};
          octet_index_d = octet_index_q + 2'd1;
          octet_value_d = '0;
          digit_count_d = '0;
        end
      end else begin
        parse_error_d = 1'b1;
      end
    end
  end

  assign ok = !parse_error_d && (octet_index_d == ipv4dq_pkg::LastIndex) &&
              (digit_count_d != '0) && (octet_value_d <= ipv4dq_pkg::OctetMax);

  assign result_o.address   = ok ? {done_octets_d, octet_value_d[7:0]} : '0;
  assign result_o.valid_res = ok;

  // A final character closes the string, so the state starts over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octet_value_q <= '0;
      digit_count_q <= '0;
      octet_index_q <= '0;
      done_octets_q <= '0;
      parse_error_q <= 1'b0;
    end else if (step_i) begin
      if (last_char_i) begin
        octet_value_q <= '0;
        digit_count_q <= '0;
        octet_index_q <= '0;
        done_octets_q <= '0;
        parse_error_q <= 1'b0;
      end else begin
        octet_value_q <= octet_value_d;
        digit_count_q <= digit_count_d;
        octet_index_q <= octet_index_d;
        done_octets_q <= done_octets_d;
        parse_error_q <= parse_error_d;
      end
    end
  end

endmodule

`default_nettype wire

[sv/ipv4_dotted_quad_parse_unit.sv]
// Dotted-decimal IPv4 parser: takes one character word per cycle, with the final
// character of a string flagged, and returns one word per string holding the
// 32-bit address (first octet in the top byte) and a valid flag; an invalid string
// gives address 0. Throughput is one character per clock, unless a final character
// stalls as below; the result of a string passes the input register and then the
// result register, around the combinational octet update. Characters keep
// flowing while a result waits; only a second final character stalls behind it.
// Depends on ipv4dq_pkg, ipv4dq_char_if, ipv4dq_addr_if and ipv4dq_core.
`default_nettype none

module ipv4_dotted_quad_parse_unit (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ipv4dq_char_if.sink    in_i,
  ipv4dq_addr_if.source  out_o
);

  logic                         in_valid_q;
  logic [ipv4dq_pkg::CharW-1:0] in_char_q;
  logic                         in_last_q;
  logic                         in_go;

  logic                         out_valid_q;
  ipv4dq_pkg::result_t          out_res_q;
  ipv4dq_pkg::result_t          core_res;

  // A final character may only move on when the result register is free or its word is being taken.
  assign in_go    = in_valid_q && (!in_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || in_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_char_q <= in_i.char_code;
      in_last_q <= in_i.last_char;
    end
  end

  ipv4dq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_go),
    .char_code_i (in_char_q),
    .last_char_i (in_last_q),
    .result_o    (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_go && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go && in_last_q) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.address   = out_res_q.address;
  assign out_o.valid_res = out_res_q.valid_res;

endmodule

`default_nettype wire

[sv/ipv4dq_checker.sv]
// Port-level checks for the dotted-quad parser, bound to its top level.
// Depends on ipv4dq_pkg and the assertion macro header.
`default_nettype none

`include "ipv4_dotted_quad_parse_unit_assert.svh"

module ipv4dq_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_i,
  input  wire logic                         in_last_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_ready_i,
  input  wire logic [ipv4dq_pkg::AddrW-1:0] out_address_i,
  input  wire logic                         out_valid_res_i
);

  logic in_last_acc;
  assign in_last_acc = in_valid_i && in_ready_i && in_last_i;

  // A new result word comes only from a final character taken at the input, through the input and result registers.
  `IPV4DQ_ASSERT_NOW(a_result_from_last, $rose(out_valid_i), $past(in_last_acc, 2))
  // An invalid string always reports a zero address.
  `IPV4DQ_ASSERT_NOW(a_invalid_zero, out_valid_i && !out_valid_res_i, out_address_i == '0)
  // With no result pending, characters are never held off.
  `IPV4DQ_ASSERT_NOW(a_free_accepts, !out_valid_i, in_ready_i)
  // A result word waits until it is taken.
  `IPV4DQ_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

endmodule

bind ipv4_dotted_quad_parse_unit ipv4dq_checker u_ipv4dq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_last_i       (in_i.last_char),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_address_i   (out_o.address),
  .out_valid_res_i (out_o.valid_res)
);

`default_nettype wire

[sim/testbench.sv]
// Testbench for ipv4_dotted_quad_parse_unit: streams address text one character word
// at a time with random idling and checks every parsed address word in order.
// Depends on ipv4dq_pkg, ipv4dq_char_if, ipv4dq_addr_if and the parser RTL.

module testbench;

  localparam int unsigned RandomChars = 750;
  localparam int unsigned CalmTail    = 120;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned StallLimit  = 2000;

  typedef struct {
    logic [ipv4dq_pkg::CharW-1:0] char_code;
    logic                         last_char;
    logic                         hold;
  } char_word_t;

  logic clk;
  logic rst_n;

  ipv4dq_char_if char_bus ();
  ipv4dq_addr_if addr_bus ();

  ipv4_dotted_quad_parse_unit u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (char_bus),
    .out_o (addr_bus)
  );

  char_word_t                   char_queue[$];
  logic [ipv4dq_pkg::CharW-1:0] addr_text[$];
  ipv4dq_pkg::result_t          addr_expected[$];
  int unsigned                  chars_total;
  int unsigned                  chars_taken;
  int unsigned                  error_count;
  int unsigned                  send_gap;
  int unsigned                  stall_left;
  int unsigned                  idle_cycles;
  char_word_t                   head;
  ipv4dq_pkg::result_t          got;
  ipv4dq_pkg::result_t          want;

  // Parser state as seen by the prediction.
  logic [ipv4dq_pkg::OctetW-1:0] cur_octet;
  logic [ipv4dq_pkg::CountW-1:0] digit_cnt;
  logic [ipv4dq_pkg::CountW-1:0] closed_cnt;
  logic [ipv4dq_pkg::DoneW-1:0]  closed_octets;
  logic                          syntax_err;

  function automatic logic no_idle();
    return chars_taken + CalmTail >= chars_total;
  endfunction

  task automatic clear_parser();
    cur_octet     = '0;
    digit_cnt     = '0;
    closed_cnt    = '0;
    closed_octets = '0;
    syntax_err    = 1'b0;
  endtask

  task automatic take_char(input logic [ipv4dq_pkg::CharW-1:0] c, input logic fin);
    logic                ok;
    ipv4dq_pkg::result_t res;
    if (!syntax_err) begin
      if (c >= ipv4dq_pkg::ZeroChar && c <= ipv4dq_pkg::NineChar) begin
        if (digit_cnt >= ipv4dq_pkg::MaxDigits) begin
          syntax_err = 1'b1;
        end else begin
          cur_octet = cur_octet * 4'd10 + {2'b00, c - ipv4dq_pkg::ZeroChar};
          digit_cnt = digit_cnt + 1'b1;
        end
      end else if (c == ipv4dq_pkg::DotChar) begin
        if (digit_cnt == '0 || closed_cnt >= ipv4dq_pkg::LastIndex ||
            cur_octet > ipv4dq_pkg::OctetMax) begin
          syntax_err = 1'b1;
        end else begin
          closed_octets = {closed_octets[ipv4dq_pkg::DoneW-9:0], cur_octet[7:0]};
          closed_cnt    = closed_cnt + 1'b1;
          cur_octet     = '0;
          digit_cnt     = '0;
        end
      end else begin
        syntax_err = 1'b1;
      end
    end
    if (fin) begin
      ok = !syntax_err && closed_cnt == ipv4dq_pkg::LastIndex && digit_cnt != '0 &&
           cur_octet <= ipv4dq_pkg::OctetMax;
      res.address   = ok ? {closed_octets, cur_octet[7:0]} : '0;
      res.valid_res = ok;
      addr_expected.push_back(res);
      clear_parser();
    end
  endtask

  task automatic report_mismatch(input string what,
                                 input logic [ipv4dq_pkg::AddrW-1:0] seen,
                                 input logic [ipv4dq_pkg::AddrW-1:0] wanted);
    $display("mismatch in %s: got %h, expected %h at %0t", what, seen, wanted, $time);
    error_count++;
  endtask

  // Moves the collected text into the word queue, flagging its final character.
  task automatic send_text(input logic hold);
    char_word_t w;
    foreach (addr_text[i]) begin
      w.char_code = addr_text[i];
      w.last_char = (i == addr_text.size() - 1);
      w.hold      = hold && (i == 0);
      char_queue.push_back(w);
    end
    chars_total += addr_text.size();
    addr_text.delete();
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) addr_text.push_back(s[i]);
    send_text(1'b0);
  endtask

  task automatic send_byte(input logic [ipv4dq_pkg::CharW-1:0] c);
    addr_text.push_back(c);
    send_text(1'b0);
  endtask

  task automatic add_octet(input int unsigned value, input int unsigned ndig);
    int unsigned scale;
    scale = 1;
    repeat (ndig - 1) scale *= 10;
    repeat (ndig) begin
      addr_text.push_back(ipv4dq_pkg::ZeroChar +
                          ipv4dq_pkg::CharW'((value / scale) % 10));
      scale /= 10;
    end
  endtask

  // Mostly dotted quads with random octets; some are broken on purpose.
  task automatic make_address();
    int unsigned n_oct;
    int unsigned flaw;
    int unsigned v;
    int unsigned nd;
    int unsigned pos;
    flaw  = $urandom_range(0, 11);
    n_oct = 4;
    if (flaw == 0) n_oct = $urandom_range(1, 3);
    else if (flaw == 1) n_oct = $urandom_range(5, 6);
    for (int k = 0; k < n_oct; k++) begin
      if (k != 0) addr_text.push_back(ipv4dq_pkg::DotChar);
      if (flaw == 2 && $urandom_range(0, 2) == 0) continue;
      case ($urandom_range(0, 7))
        0: begin
          v  = $urandom_range(256, 999);
          nd = 3;
        end
        1: begin
          v  = $urandom_range(0, 255);
          nd = 3;
        end
        2: begin
          v  = $urandom_range(250, 259);
          nd = 3;
        end
        default: begin
          v  = $urandom_range(0, 255);
          nd = (v > 99) ? 3 : (v > 9) ? 2 : 1;
        end
      endcase
      add_octet(v, nd);
      // An octet with one digit too many.
      if (flaw == 3 && nd == 3 && $urandom_range(0, 1) == 0) add_octet($urandom_range(0, 9), 1);
    end
    if (flaw == 4) begin
      pos = $urandom_range(0, addr_text.size() - 1);
      addr_text[pos] = ipv4dq_pkg::CharW'($urandom_range(0, 255));
    end else if (flaw == 5) begin
      addr_text.push_back(ipv4dq_pkg::DotChar);
    end
  endtask

  task automatic make_noise();
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 3))
        0: addr_text.push_back(ipv4dq_pkg::ZeroChar +
                               ipv4dq_pkg::CharW'($urandom_range(0, 9)));
        1:       addr_text.push_back(ipv4dq_pkg::DotChar);
        default: addr_text.push_back(ipv4dq_pkg::CharW'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    int unsigned n_strings;
    rst_n              = 1'b0;
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    char_bus.last_char = 1'b0;
    addr_bus.ready     = 1'b0;
    chars_total        = 0;
    chars_taken        = 0;
    error_count        = 0;
    send_gap           = 0;
    stall_left         = 0;
    idle_cycles        = 0;
    clear_parser();

    send_string("0.0.0.0");
    send_string("255.255.255.255");
    send_string("1234");
    send_string(".1.2.3");
    send_string("1..2.3");
    send_string("1.2.3.4.");
    send_string("1.2.3.4x");
    send_string("256.1.1.1");
    send_string("1.1.1.999");
    send_string("1.2.3.");
    send_string("1.2.3");
    send_string("7");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ipv4dq_pkg::ZeroChar - 1'b1);
    send_byte(ipv4dq_pkg::NineChar + 1'b1);

    n_strings = 0;
    while (chars_total < RandomChars) begin
      if ($urandom_range(0, 9) == 0) make_noise();
      else make_address();
      // The first random string, and a few others, wait for the results to drain.
      send_text(n_strings == 0 || $urandom_range(0, 49) == 0);
      n_strings++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (chars_taken != chars_total || addr_expected.size() != 0);
    repeat (DrainCycles) @(posedge clk);
    if (addr_expected.size() != 0) report_mismatch("missing result", '0, '0);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Character driver.
  always @(posedge clk) begin
    if (rst_n) begin
      if (char_bus.valid && char_bus.ready) begin
        take_char(char_bus.char_code, char_bus.last_char);
        chars_taken++;
      end
      if (!char_bus.valid || char_bus.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          char_bus.valid <= 1'b0;
        end else if (char_queue.size() == 0 ||
                     (char_queue[0].hold && addr_expected.size() != 0)) begin
          char_bus.valid <= 1'b0;
        end else if (!no_idle() && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 15);
          char_bus.valid <= 1'b0;
        end else begin
          head = char_queue.pop_front();
          char_bus.char_code <= head.char_code;
          char_bus.last_char <= head.last_char;
          char_bus.valid     <= 1'b1;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst_n) begin
      if (addr_bus.valid && addr_bus.ready) begin
        got.address   = addr_bus.address;
        got.valid_res = addr_bus.valid_res;
        if (addr_expected.size() == 0) begin
          report_mismatch("unexpected result", got.address, '0);
        end else begin
          want = addr_expected.pop_front();
          if (got.address !== want.address) report_mismatch("address", got.address,
                                                            want.address);
          if (got.valid_res !== want.valid_res) begin
            report_mismatch("valid_res", ipv4dq_pkg::AddrW'(got.valid_res),
                            ipv4dq_pkg::AddrW'(want.valid_res));
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        addr_bus.ready <= 1'b0;
      end else if (!no_idle() && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        addr_bus.ready <= 1'b0;
      end else begin
        addr_bus.ready <= 1'b1;
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((char_bus.valid && char_bus.ready) || (addr_bus.valid && addr_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles == StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
